### rtl/ea2rm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ea2rm_pkg
// Shared constants, types and helpers for the Euler angle to rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package ea2rm_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 14;

    // internal fixed point: Q30
    localparam int WORK_BITS = 30;
    localparam longint unsigned HALF_PI_Q = 64'd1686629713;

    localparam int SC_W      = 32;  // signed sine/cosine, range +-2^30
    localparam int THETA_W   = 31;
    localparam int TH2_W     = 32;
    localparam int TERM_W    = 33;  // series terms and dividend width
    localparam int SUM_W     = 36;
    localparam int SERIES_N  = 8;   // cosine terms beyond 1; sine uses seven beyond theta

    // theta, theta^2, two stages per term, final clamp
    localparam int SC_LATENCY  = 2 + 2 * SERIES_N + 1;
    // first products, second products, add, round and permute
    localparam int MAT_LATENCY = 4;

    localparam int ENTRY_W = SC_W + 1;

    // axis permutations: even parity slots 0..2, odd parity slots 3..5
    localparam logic [1:0] AXIS_PERM [6][3] = '{
        '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1},
        '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2}, '{2'd2, 2'd1, 2'd0}
    };

    typedef struct packed {
        logic       rep;
        logic [2:0] slot;
    } ctrl_t;

    // position x in (i,j,k) order whose axis is p
    function automatic logic [1:0] perm_pos(input logic [2:0] slot, input logic [1:0] p);
        logic [1:0] x;
        x = 2'd0;
        for (int n = 0; n < 3; n++) begin
            if (AXIS_PERM[slot][n] == p) begin
                x = 2'(n);
            end
        end
        return x;
    endfunction

endpackage

### rtl/ea2rm_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ea2rm_sincos
// Pipelined Q30 sine and cosine of a binary angle by truncated Taylor
// series, one term per two stages.
// ----------------------------------------------------------------------------
module ea2rm_sincos import ea2rm_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [ANGLE_BITS-1:0]  angle,
    output logic signed [SC_W-1:0] sin_q,
    output logic signed [SC_W-1:0] cos_q
);

    localparam int QB = ANGLE_BITS - 2;
    localparam logic [WORK_BITS:0] ONE = (WORK_BITS+1)'(1) << WORK_BITS;

    logic [WORK_BITS-1:0] t_frac;
    logic [1:0]           q0_reg;
    logic [THETA_W-1:0]   theta0_reg;

    // b side, index 0 is the theta^2 stage
    logic [TERM_W-1:0]       ts_reg [SERIES_N+1];
    logic [TERM_W-1:0]       tc_reg [SERIES_N+1];
    logic signed [SUM_W-1:0] ssb_reg [SERIES_N+1];
    logic signed [SUM_W-1:0] csb_reg [SERIES_N+1];
    logic [TH2_W-1:0]        th2b_reg [SERIES_N+1];
    logic [1:0]              qb_reg [SERIES_N+1];

    logic signed [SC_W-1:0]  sin_reg;
    logic signed [SC_W-1:0]  cos_reg;

    assign t_frac = {angle[QB-1:0], {(WORK_BITS-QB){1'b0}}};

    always_ff @(posedge aclk) begin
        if (en) begin
            q0_reg     <= angle[ANGLE_BITS-1 -: 2];
            theta0_reg <= THETA_W'((64'(t_frac) * HALF_PI_Q) >> WORK_BITS);
            qb_reg[0]   <= q0_reg;
            th2b_reg[0] <= TH2_W'((64'(theta0_reg) * 64'(theta0_reg)) >> WORK_BITS);
            ts_reg[0]   <= TERM_W'(theta0_reg);
            tc_reg[0]   <= TERM_W'(ONE);
            ssb_reg[0]  <= $signed(SUM_W'(theta0_reg));
            csb_reg[0]  <= $signed(SUM_W'(ONE));
        end
    end

    for (genvar k = 1; k <= SERIES_N; k++) begin : g_step
        localparam longint DS = 2 * k * (2 * k + 1);
        localparam longint DC = (2 * k - 1) * (2 * k);
        localparam int     SS = TERM_W + $clog2(DS);
        localparam int     SCH = TERM_W + $clog2(DC);
        localparam longint MS = ((longint'(1) << SS) + DS - 1) / DS;
        localparam longint MC = ((longint'(1) << SCH) + DC - 1) / DC;

        logic [TERM_W-1:0]       ps_reg, pc_reg;
        logic signed [SUM_W-1:0] ssa_reg, csa_reg;
        logic [TH2_W-1:0]        th2a_reg;
        logic [1:0]              qa_reg;
        logic signed [SUM_W-1:0] ts_add, tc_add;

        // fold in the previous term; odd-numbered terms subtract
        always_comb begin
            ts_add = $signed(SUM_W'(ts_reg[k-1]));
            tc_add = $signed(SUM_W'(tc_reg[k-1]));
            if (k == 1) begin
                ts_add = '0;
                tc_add = '0;
            end else if (((k - 1) % 2) == 1) begin
                ts_add = -ts_add;
                tc_add = -tc_add;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (k < SERIES_N) begin
                    ps_reg <= TERM_W'((65'(ts_reg[k-1]) * 65'(th2b_reg[k-1])) >> WORK_BITS);
                end else begin
                    ps_reg <= '0;
                end
                pc_reg   <= TERM_W'((65'(tc_reg[k-1]) * 65'(th2b_reg[k-1])) >> WORK_BITS);
                ssa_reg  <= ssb_reg[k-1] + ts_add;
                csa_reg  <= csb_reg[k-1] + tc_add;
                th2a_reg <= th2b_reg[k-1];
                qa_reg   <= qb_reg[k-1];

                // divide by constant through exact reciprocal
                ts_reg[k]   <= TERM_W'((96'(ps_reg) * 96'(MS)) >> SS);
                tc_reg[k]   <= TERM_W'((96'(pc_reg) * 96'(MC)) >> SCH);
                ssb_reg[k]  <= ssa_reg;
                csb_reg[k]  <= csa_reg;
                th2b_reg[k] <= th2a_reg;
                qb_reg[k]   <= qa_reg;
            end
        end
    end

    logic signed [SUM_W-1:0] s_sum, c_sum;
    logic signed [SC_W-1:0]  s_cl, c_cl;

    always_comb begin
        s_sum = ssb_reg[SERIES_N] + $signed(SUM_W'(ts_reg[SERIES_N]));
        c_sum = csb_reg[SERIES_N] + $signed(SUM_W'(tc_reg[SERIES_N]));
        priority if (s_sum < 0) begin
            s_cl = '0;
        end else if (s_sum > $signed(SUM_W'(ONE))) begin
            s_cl = $signed(SC_W'(ONE));
        end else begin
            s_cl = SC_W'(s_sum);
        end
        priority if (c_sum < 0) begin
            c_cl = '0;
        end else if (c_sum > $signed(SUM_W'(ONE))) begin
            c_cl = $signed(SC_W'(ONE));
        end else begin
            c_cl = SC_W'(c_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            unique case (qb_reg[SERIES_N])
                2'd0: begin sin_reg <= s_cl;  cos_reg <= c_cl;  end
                2'd1: begin sin_reg <= c_cl;  cos_reg <= -s_cl; end
                2'd2: begin sin_reg <= -s_cl; cos_reg <= -c_cl; end
                default: begin sin_reg <= -c_cl; cos_reg <= s_cl; end
            endcase
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

### rtl/ea2rm_mat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ea2rm_mat
// Combines three sine/cosine pairs into the nine matrix entries: two
// product stages, an add stage, then rounding, saturation and axis order.
// ----------------------------------------------------------------------------
module ea2rm_mat import ea2rm_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  ctrl_t                         ctrl,
    input  logic signed [SC_W-1:0]        si,
    input  logic signed [SC_W-1:0]        ci,
    input  logic signed [SC_W-1:0]        sj,
    input  logic signed [SC_W-1:0]        cj,
    input  logic signed [SC_W-1:0]        sh,
    input  logic signed [SC_W-1:0]        ch,
    output logic [9*(FRACTION_BITS+2)-1:0] entries
);

    localparam int OUT_W = FRACTION_BITS + 2;
    localparam int RSH   = WORK_BITS - FRACTION_BITS;
    localparam logic signed [SC_W-1:0] ONE = SC_W'(1) <<< WORK_BITS;
    localparam logic signed [ENTRY_W:0] LIM = (ENTRY_W+1)'(1) <<< FRACTION_BITS;

    function automatic logic signed [SC_W-1:0] mulq(input logic signed [SC_W-1:0] a,
                                                    input logic signed [SC_W-1:0] b);
        logic signed [2*SC_W-1:0] p;
        p = (2*SC_W)'(a) * (2*SC_W)'(b) + ((2*SC_W)'(1) <<< (WORK_BITS - 1));
        return SC_W'(p >>> WORK_BITS);
    endfunction

    // stage 0
    ctrl_t                  ctrl0_reg;
    logic signed [SC_W-1:0] cc_reg, cs_reg, sc_reg, ss_reg;
    logic signed [SC_W-1:0] si_reg, ci_reg, sj_reg, cj_reg, sh_reg, ch_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl0_reg <= ctrl;
            cc_reg <= mulq(ci, ch);
            cs_reg <= mulq(ci, sh);
            sc_reg <= mulq(si, ch);
            ss_reg <= mulq(si, sh);
            si_reg <= si; ci_reg <= ci; sj_reg <= sj;
            cj_reg <= cj; sh_reg <= sh; ch_reg <= ch;
        end
    end

    // entry (x,y) in (i,j,k) order = +-mulq(a,b) + addend
    logic signed [SC_W-1:0] opa [3][3];
    logic signed [SC_W-1:0] opb [3][3];
    logic signed [SC_W-1:0] addv [3][3];
    logic                   neg [3][3];

    always_comb begin
        for (int x = 0; x < 3; x++) begin
            for (int y = 0; y < 3; y++) begin
                neg[x][y]  = 1'b0;
                addv[x][y] = '0;
            end
        end
        if (ctrl0_reg.rep) begin
            opa[0][0] = cj_reg; opb[0][0] = ONE;
            opa[1][0] = sj_reg; opb[1][0] = si_reg;
            opa[2][0] = sj_reg; opb[2][0] = ci_reg;
            opa[0][1] = sj_reg; opb[0][1] = sh_reg;
            opa[1][1] = cj_reg; opb[1][1] = ss_reg; neg[1][1] = 1'b1; addv[1][1] = cc_reg;
            opa[2][1] = cj_reg; opb[2][1] = cs_reg; neg[2][1] = 1'b1; addv[2][1] = -sc_reg;
            opa[0][2] = sj_reg; opb[0][2] = ch_reg; neg[0][2] = 1'b1;
            opa[1][2] = cj_reg; opb[1][2] = sc_reg; addv[1][2] = cs_reg;
            opa[2][2] = cj_reg; opb[2][2] = cc_reg; addv[2][2] = -ss_reg;
        end else begin
            opa[0][0] = cj_reg; opb[0][0] = ch_reg;
            opa[1][0] = sj_reg; opb[1][0] = sc_reg; addv[1][0] = -cs_reg;
            opa[2][0] = sj_reg; opb[2][0] = cc_reg; addv[2][0] = ss_reg;
            opa[0][1] = cj_reg; opb[0][1] = sh_reg;
            opa[1][1] = sj_reg; opb[1][1] = ss_reg; addv[1][1] = cc_reg;
            opa[2][1] = sj_reg; opb[2][1] = cs_reg; addv[2][1] = -sc_reg;
            opa[0][2] = sj_reg; opb[0][2] = ONE;    neg[0][2] = 1'b1;
            opa[1][2] = cj_reg; opb[1][2] = si_reg;
            opa[2][2] = cj_reg; opb[2][2] = ci_reg;
        end
    end

    // stage 1 and 2
    ctrl_t                     ctrl1_reg, ctrl2_reg;
    logic signed [SC_W-1:0]    prod_reg [3][3];
    logic signed [SC_W-1:0]    add1_reg [3][3];
    logic signed [ENTRY_W-1:0] ent_reg  [3][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl1_reg <= ctrl0_reg;
            ctrl2_reg <= ctrl1_reg;
            for (int x = 0; x < 3; x++) begin
                for (int y = 0; y < 3; y++) begin
                    prod_reg[x][y] <= neg[x][y] ? -mulq(opa[x][y], opb[x][y])
                                                :  mulq(opa[x][y], opb[x][y]);
                    add1_reg[x][y] <= addv[x][y];
                    ent_reg[x][y]  <= ENTRY_W'(prod_reg[x][y]) + ENTRY_W'(add1_reg[x][y]);
                end
            end
        end
    end

    // stage 3: round, saturate, place by axis
    logic [1:0]                pos [3];
    logic signed [ENTRY_W:0]   rnd [3][3];
    logic [OUT_W-1:0]          sat [3][3];
    logic [OUT_W-1:0]          out_reg [3][3];

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            pos[p] = perm_pos(ctrl2_reg.slot, 2'(p));
        end
        for (int x = 0; x < 3; x++) begin
            for (int y = 0; y < 3; y++) begin
                rnd[x][y] = ((ENTRY_W+1)'(ent_reg[x][y]) + ((ENTRY_W+1)'(1) <<< (RSH - 1)))
                            >>> RSH;
                priority if (rnd[x][y] > LIM) begin
                    sat[x][y] = OUT_W'(LIM);
                end else if (rnd[x][y] < -LIM) begin
                    sat[x][y] = OUT_W'(-LIM);
                end else begin
                    sat[x][y] = OUT_W'(rnd[x][y]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < 3; p++) begin
                for (int q = 0; q < 3; q++) begin
                    out_reg[p][q] <= sat[pos[p]][pos[q]];
                end
            end
        end
    end

    for (genvar n = 0; n < 9; n++) begin : g_pack
        assign entries[n*OUT_W +: OUT_W] = out_reg[n/3][n%3];
    end

endmodule

### rtl/euler_angles_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so s_tready = !m_tvalid | m_tready.
// Reset: aresetn (synchronous, active low) clears the valid bits only;
// data registers are not reset.
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix
// Euler angle triple in any of the 24 axis orders to a 3x3 rotation
// matrix with Q2.14 entries.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix import ea2rm_pkg::*; #(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int IN_W  = ((5 + 3 * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((9 * (FRACTION_BITS + 2) + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // first_axis, odd_parity, repeated_axis, rotating_frame, angle_a,
    // angle_b, angle_c
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // m_r0_c0, m_r0_c1, m_r0_c2, m_r1_c0, ..., m_r2_c2
    output logic [OUT_W-1:0] m_tdata
);

    localparam int LAT = SC_LATENCY + MAT_LATENCY;
    localparam int ENT_W = 9 * (FRACTION_BITS + 2);

    logic                  en;
    logic [1:0]            first_axis;
    logic                  odd_parity, repeated_axis, rotating_frame;
    logic [ANGLE_BITS-1:0] angle_a, angle_b, angle_c;
    logic [ANGLE_BITS-1:0] ang_i, ang_j, ang_h;
    ctrl_t                 ctrl_in;
    logic [LAT-1:0]        vld_reg;
    ctrl_t                 ctrl_reg [SC_LATENCY];
    logic signed [SC_W-1:0] si, ci, sj, cj, sh, ch;
    logic [ENT_W-1:0]      entries;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign first_axis     = s_tdata[1:0];
    assign odd_parity     = s_tdata[2];
    assign repeated_axis  = s_tdata[3];
    assign rotating_frame = s_tdata[4];
    assign angle_a        = s_tdata[5 +: ANGLE_BITS];
    assign angle_b        = s_tdata[5 + ANGLE_BITS +: ANGLE_BITS];
    assign angle_c        = s_tdata[5 + 2 * ANGLE_BITS +: ANGLE_BITS];

    // swap for rotating frame, negate mod 2^ANGLE_BITS for odd parity
    always_comb begin
        ang_i = rotating_frame ? angle_c : angle_a;
        ang_j = angle_b;
        ang_h = rotating_frame ? angle_a : angle_c;
        if (odd_parity) begin
            ang_i = -ang_i;
            ang_j = -ang_j;
            ang_h = -ang_h;
        end
        ctrl_in.rep  = repeated_axis;
        ctrl_in.slot = 3'(odd_parity) * 3'd3 + ((first_axis == 2'd3) ? 3'd0 : 3'(first_axis));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl_reg[0] <= ctrl_in;
            for (int n = 1; n < SC_LATENCY; n++) begin
                ctrl_reg[n] <= ctrl_reg[n-1];
            end
        end
    end

    ea2rm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_i (
        .aclk(aclk), .en(en), .angle(ang_i), .sin_q(si), .cos_q(ci)
    );
    ea2rm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_j (
        .aclk(aclk), .en(en), .angle(ang_j), .sin_q(sj), .cos_q(cj)
    );
    ea2rm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_h (
        .aclk(aclk), .en(en), .angle(ang_h), .sin_q(sh), .cos_q(ch)
    );

    ea2rm_mat #(.FRACTION_BITS(FRACTION_BITS)) u_mat (
        .aclk(aclk), .en(en), .ctrl(ctrl_reg[SC_LATENCY-1]),
        .si(si), .ci(ci), .sj(sj), .cj(cj), .sh(sh), .ch(ch),
        .entries(entries)
    );

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = OUT_W'(entries);

endmodule

### rtl/ea2rm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ea2rm_checker
// Port-level checks on the rotation matrix pipeline, bound to the top.
// ----------------------------------------------------------------------------
module ea2rm_checker import ea2rm_pkg::*; #(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int IN_W  = ((5 + 3 * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((9 * (FRACTION_BITS + 2) + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int EW = FRACTION_BITS + 2;
    localparam logic signed [EW-1:0] LIM = EW'(1) <<< FRACTION_BITS;

    logic in_range;

    always_comb begin
        in_range = 1'b1;
        for (int n = 0; n < 9; n++) begin
            if ($signed(m_tdata[n*EW +: EW]) > LIM || $signed(m_tdata[n*EW +: EW]) < -LIM) begin
                in_range = 1'b0;
            end
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !$past(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output register state");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    a_entry_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> in_range)
        else $error("matrix entry outside plus or minus one");

    // a waiting input item must stay on the bus unchanged
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("waiting input item changed");

endmodule

bind euler_angles_to_rotation_matrix ea2rm_checker #(
    .ANGLE_BITS(ANGLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
) u_ea2rm_checker (.*);
